>>> src/rtt_statistics_unit_top_macros.svh
// ----------------------------------------------------------------------------
// rtt statistics unit assertion macros
// shared assertion wrappers for the statistics unit
// ----------------------------------------------------------------------------
`ifndef RTT_STATISTICS_UNIT_TOP_MACROS_SVH
`define RTT_STATISTICS_UNIT_TOP_MACROS_SVH

// property checked on every clock edge out of reset
`define RTTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define RTTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rtts_pkg.sv
// ----------------------------------------------------------------------------
// rtts_pkg
// types, sizes and width helpers for the round-trip time statistics unit
// ----------------------------------------------------------------------------
package rtts_pkg;

    localparam int MAX_SAMPLES   = 1024;
    localparam int SAMPLE_BITS   = 24;

    localparam int SAMPLE_W      = 24;
    localparam int COUNT_FIELD_W = 11;

    localparam int ADDR_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_BITS + ADDR_W;
    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int ACC_FULL = 2 * SAMPLE_BITS + ADDR_W;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int NUM_W    = ACC_W;
    localparam int ROOT_W   = (NUM_W + 1) / 2;
    localparam int RAD_W    = 2 * ROOT_W;

    localparam int DIV_STEP_W  = $clog2(NUM_W);
    localparam int SQRT_STEP_W = $clog2(ROOT_W);
    localparam int SQ_STEP_W   = $clog2(SAMPLE_BITS);

    localparam int WIDE_S_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int WIDE_R_W = (ROOT_W > SAMPLE_W) ? ROOT_W : SAMPLE_W;
    localparam int WIDE_C_W = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample_us;
    } t_in_beat;

    typedef struct packed {
        logic [SAMPLE_W-1:0]      min_us;
        logic [SAMPLE_W-1:0]      max_us;
        logic [SAMPLE_W-1:0]      mean_us;
        logic [SAMPLE_W-1:0]      stddev_us;
        logic [COUNT_FIELD_W-1:0] sample_count;
        logic                     empty_res;
        logic                     dropped;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_READ,
        S_SQ_GO,
        S_SQ_WAIT,
        S_VAR_GO,
        S_VAR,
        S_ROOT,
        S_OUT
    } t_state;

    function automatic logic [SAMPLE_BITS-1:0] field_to_sample(input logic [SAMPLE_W-1:0] v);
        logic [WIDE_S_W-1:0] t;
        t = WIDE_S_W'(v);
        return t[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_to_field(input logic [SAMPLE_BITS-1:0] v);
        logic [WIDE_S_W-1:0] t;
        t = WIDE_S_W'(v);
        return t[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] root_to_field(input logic [ROOT_W-1:0] v);
        logic [WIDE_R_W-1:0] t;
        t = WIDE_R_W'(v);
        return t[SAMPLE_W-1:0];
    endfunction

    function automatic logic [COUNT_FIELD_W-1:0] count_to_field(input logic [CNT_W-1:0] v);
        logic [WIDE_C_W-1:0] t;
        t = WIDE_C_W'(v);
        return t[COUNT_FIELD_W-1:0];
    endfunction

endpackage

>>> src/rtts_div.sv
// ----------------------------------------------------------------------------
// rtts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtts_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rtts_pkg::NUM_W-1:0] i_num,
    input  logic [rtts_pkg::CNT_W-1:0] i_den,
    output logic                      o_done,
    output logic [rtts_pkg::NUM_W-1:0] o_quo
);
    import rtts_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [NUM_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_den;

    logic [CNT_W:0]        trial;
    logic                  ge;
    logic [CNT_W:0]        diff;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> src/rtts_sqr.sv
// ----------------------------------------------------------------------------
// rtts_sqr
// bit-serial squarer, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module rtts_sqr (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rtts_pkg::SAMPLE_BITS-1:0] i_val,
    output logic                            o_done,
    output logic [rtts_pkg::SQ_W-1:0]       o_prod
);
    import rtts_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [SQ_STEP_W-1:0]   r_step;
    logic [SAMPLE_BITS-1:0] r_mcand;
    logic [SAMPLE_BITS-1:0] r_mplier;
    logic [SQ_W-1:0]        r_prod;

    logic [SQ_W-1:0]        n_prod;

    assign n_prod = {r_prod[SQ_W-2:0], 1'b0}
                  + (r_mplier[SAMPLE_BITS-1] ? SQ_W'(r_mcand) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SQ_STEP_W'(SAMPLE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_val;
            r_mplier <= i_val;
            r_prod   <= '0;
        end else if (r_busy) begin
            r_mplier <= {r_mplier[SAMPLE_BITS-2:0], 1'b0};
            r_prod   <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

>>> src/rtts_sqrt.sv
// ----------------------------------------------------------------------------
// rtts_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module rtts_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rtts_pkg::NUM_W-1:0]  i_rad,
    output logic                       o_done,
    output logic [rtts_pkg::ROOT_W-1:0] o_root
);
    import rtts_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [SQRT_STEP_W-1:0] r_step;
    logic [RAD_W-1:0]       r_rad;
    logic [ROOT_W-1:0]      r_rem;
    logic [ROOT_W-1:0]      r_root;

    logic [ROOT_W+1:0]      shifted;
    logic [ROOT_W+1:0]      trial;
    logic                   ge;
    logic [ROOT_W+1:0]      n_rem;

    assign shifted = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial   = {r_root, 2'b01};
    assign ge      = shifted >= trial;
    assign n_rem   = ge ? (shifted - trial) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SQRT_STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below 2^ROOT_W until the final step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= n_rem[ROOT_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> src/rtt_statistics_unit_top.sv
// ----------------------------------------------------------------------------
// rtt_statistics_unit_top
// round-trip time statistics: stores samples, reports min, max, mean, deviation
// ----------------------------------------------------------------------------
// channel  direction  handshake                  beat
// in       input      i_in_valid / o_in_ready    t_in_beat  (action, sample_us)
// out      output     o_out_valid / i_out_ready  t_out_beat (statistics report)
//
// add beats are taken one per cycle, back to back, while no report runs
// a report on an empty store goes straight to the output; with one sample it runs only the
//   mean division; otherwise it runs the serial divider for the mean, the serial squarer per
//   stored sample, the divider again for the variance and then the root unit
// o_in_ready is low while a report runs; a finished report waits in its last
//   state only while the output register still holds an untaken beat
// no clearing pass after reset: the store is read only below the fill count
// ----------------------------------------------------------------------------
`include "rtt_statistics_unit_top_macros.svh"

module rtt_statistics_unit_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rtts_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rtts_pkg::t_out_beat  o_out_data
);
    import rtts_pkg::*;

    t_state                 r_state;
    t_state                 n_state;

    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic                   r_ovf;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [CNT_W-1:0]       r_idx;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic [ACC_W-1:0]       r_acc;
    logic [ROOT_W-1:0]      r_dev;

    logic                   r_out_valid;
    t_out_beat              r_out_data;

    logic                   in_acc;
    logic                   add_acc;
    logic                   rpt_acc;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   store_full;
    logic                   out_free;
    logic                   load_out;
    logic                   last_sample;
    logic                   is_empty;

    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_num;
    logic [CNT_W-1:0]       div_den;
    logic [NUM_W-1:0]       div_quo;

    logic                   sq_start;
    logic                   sq_done;
    logic [SAMPLE_BITS-1:0] sq_val;
    logic [SQ_W-1:0]        sq_prod;

    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [ROOT_W-1:0]      sqrt_root;

    logic [ACC_W:0]         acc_sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign add_acc     = in_acc & ~i_in_data.action;
    assign rpt_acc     = in_acc & i_in_data.action;
    assign sample      = field_to_sample(i_in_data.sample_us);
    assign store_full  = (r_count == CNT_W'(MAX_SAMPLES));
    assign out_free    = ~r_out_valid | i_out_ready;
    assign load_out    = (r_state == S_OUT) & out_free;
    assign last_sample = (r_idx == r_count - 1'b1);
    assign is_empty    = (r_count == '0);

    assign div_num = (r_state == S_VAR_GO) ? r_acc : NUM_W'(r_sum);
    assign div_den = (r_state == S_VAR_GO) ? (r_count - 1'b1) : r_count;
    assign sq_val  = (r_rd_data >= r_mean) ? (r_rd_data - r_mean) : (r_mean - r_rd_data);
    assign acc_sum = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(sq_prod);

    rtts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    rtts_sqr u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_prod  (sq_prod)
    );

    rtts_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (div_quo),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        sqrt_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (rpt_acc) begin
                    if (is_empty) begin
                        n_state = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_MEAN;
                    end
                end
            end
            S_MEAN: begin
                if (div_done) begin
                    n_state = (r_count == CNT_W'(1)) ? S_OUT : S_READ;
                end
            end
            S_READ: begin
                n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                sq_start = 1'b1;
                n_state  = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (sq_done) begin
                    n_state = last_sample ? S_VAR_GO : S_READ;
                end
            end
            S_VAR_GO: begin
                div_start = 1'b1;
                n_state   = S_VAR;
            end
            S_VAR: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // running statistics, cleared as the report leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_ovf   <= 1'b0;
        end else if (load_out) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_ovf   <= 1'b0;
        end else if (add_acc) begin
            if (store_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(sample);
                if (sample < r_min) begin
                    r_min <= sample;
                end
                if (sample > r_max) begin
                    r_max <= sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_acc && !store_full) begin
            r_mem[r_count[ADDR_W-1:0]] <= sample;
        end
        r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rpt_acc) begin
            r_mean <= '0;
            r_dev  <= '0;
        end else begin
            if (r_state == S_MEAN && div_done) begin
                r_mean <= div_quo[SAMPLE_BITS-1:0];
            end
            if (r_state == S_ROOT && sqrt_done) begin
                r_dev <= sqrt_root;
            end
        end
        if (r_state == S_MEAN && div_done) begin
            r_idx <= '0;
            r_acc <= '0;
        end else if (r_state == S_SQ_WAIT && sq_done) begin
            r_idx <= r_idx + 1'b1;
            r_acc <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.min_us       <= is_empty ? '0 : sample_to_field(r_min);
            r_out_data.max_us       <= is_empty ? '0 : sample_to_field(r_max);
            r_out_data.mean_us      <= sample_to_field(r_mean);
            r_out_data.stddev_us    <= root_to_field(r_dev);
            r_out_data.sample_count <= count_to_field(r_count);
            r_out_data.empty_res    <= is_empty;
            r_out_data.dropped      <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RTTS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_SAMPLES), "fill count past store depth")
    `RTTS_ASSERT(a_read_in_range, i_clk, i_rst_n, (r_state == S_READ) |-> (r_idx < r_count), "store read beyond fill count")
    `RTTS_ASSERT_NEXT(a_report_clears, i_clk, i_rst_n, load_out, (r_count == '0) && r_out_valid && (r_state == S_IDLE), "report did not clear statistics")
    `RTTS_ASSERT(a_empty_zero, i_clk, i_rst_n, (r_out_valid && r_out_data.empty_res) |-> (r_out_data.sample_count == '0 && r_out_data.stddev_us == '0), "empty report with data")

endmodule
